### rtl/sorted_priority_queue_defines.svh
// Assertion macros used by the sorted priority queue RTL.
// No dependencies; include by bare file name.
`ifndef SORTED_PRIORITY_QUEUE_DEFINES_SVH
`define SORTED_PRIORITY_QUEUE_DEFINES_SVH

// Implication checked every clock edge, disabled in reset.
`define SPQ_ASSERT_IMP(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled in reset.
`define SPQ_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### rtl/spq_pkg.sv
// Package for the sorted priority queue: command and status codes, payload structs.
// No dependencies.
package spq_pkg;
    localparam logic [1:0] CMD_INSERT = 2'd0;
    localparam logic [1:0] CMD_REMOVE = 2'd1;
    localparam logic [1:0] CMD_POP    = 2'd2;
    localparam logic [1:0] CMD_DECKEY = 2'd3;

    localparam logic [1:0] ST_DONE  = 2'd0;
    localparam logic [1:0] ST_MISS  = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;

    typedef struct packed {
        logic [1:0]  cmd;
        logic [15:0] node_id;
        logic [31:0] key_in;
    } t_in_item;

    typedef struct packed {
        logic [15:0] out_node;
        logic [31:0] out_key;
        logic [1:0]  status;
        logic [6:0]  entry_count;
    } t_out_item;
endpackage

### rtl/sorted_priority_queue.sv
// Sorted priority queue: one command at a time, entries held sorted in a RAM.
// A pop or remove on an empty queue goes straight to done with a miss status.
// Any other command walks the RAM one entry per cycle (search, then shift),
// set by the single RAM read port. busy is high while a command runs; the
// result appears for one cycle with o_done and cannot be stalled. Out of reset
// the queue is empty; no clearing pass is needed.
// Depends on spq_pkg, spq_ram and sorted_priority_queue_defines.svh.
`include "sorted_priority_queue_defines.svh"

module sorted_priority_queue #(
    parameter int CAPACITY  = 64,
    parameter int KEY_WIDTH = 32
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    input  logic              start,
    output logic              busy,
    input  spq_pkg::t_in_item i_item,
    output logic              o_done,
    output spq_pkg::t_out_item o_item
);
    localparam int AW = $clog2(CAPACITY);
    localparam int CW = $clog2(CAPACITY + 1);
    localparam int EW = 16 + KEY_WIDTH;

    localparam logic [3:0] S_IDLE  = 4'd0;
    localparam logic [3:0] S_FIND  = 4'd1;  // scan for id, read issued
    localparam logic [3:0] S_DEL   = 4'd2;  // shift left from delete point
    localparam logic [3:0] S_INS   = 4'd3;  // scan from top for insert point
    localparam logic [3:0] S_DONE  = 4'd4;
    localparam logic [3:0] S_PREP  = 4'd5;  // check room, then set up the insert scan

    logic [3:0]           r_state, n_state;
    logic [1:0]           r_cmd;
    logic [15:0]          r_id;
    logic [KEY_WIDTH-1:0] r_key;
    logic [CW-1:0]        r_cnt;
    logic [CW-1:0]        r_pos;        // running index
    logic [15:0]          r_onode;
    logic [KEY_WIDTH-1:0] r_okey;
    logic [1:0]           r_st;
    logic                 r_rd;         // read in flight for r_rpos

    logic                 we;
    logic [AW-1:0]        waddr, raddr;
    logic [EW-1:0]        wdata, rdata;
    logic [15:0]          rd_id;
    logic [KEY_WIDTH-1:0] rd_key;

    spq_ram #(.WIDTH(EW), .DEPTH(CAPACITY)) u_ram (
        .i_clk(i_clk), .i_we(we), .i_waddr(waddr), .i_wdata(wdata),
        .i_raddr(raddr), .o_rdata(rdata)
    );

    assign rd_id  = rdata[EW-1 -: 16];
    assign rd_key = rdata[KEY_WIDTH-1:0];
    assign busy   = (r_state != S_IDLE);

    // r_pos is the address read this cycle; rdata next cycle holds entry r_pos-prev.
    logic [CW-1:0] r_rpos;

    always_comb begin
        n_state = r_state;
        we      = 1'b0;
        waddr   = r_rpos[AW-1:0];
        wdata   = {r_id, r_key};
        raddr   = r_pos[AW-1:0];
        unique case (r_state)
            S_IDLE, S_DONE, S_PREP: ;
            S_FIND: ;
            S_DEL: begin
                // entry r_rpos read; write it one slot down
                if (r_rd) begin
                    we    = 1'b1;
                    waddr = AW'(r_rpos - CW'(1));
                    wdata = rdata;
                end
            end
            S_INS: begin
                // entry r_rpos read; shift up if its key exceeds the new key
                if (r_rd) begin
                    we = 1'b1;
                    if (rd_key > r_key) begin
                        waddr = AW'(r_rpos + CW'(1));
                        wdata = rdata;
                    end else begin
                        waddr = AW'(r_rpos + CW'(1));
                    end
                end else if (r_pos == '0 && r_rpos == '1) begin
                    we    = 1'b1;
                    waddr = '0;
                end
            end
            default: ;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            o_done  <= 1'b0;
            r_rd    <= 1'b0;
        end else begin
            o_done <= (r_state == S_DONE);
            unique case (r_state)
                S_IDLE: begin
                    if (start) begin
                        r_cmd   <= i_item.cmd;
                        r_id    <= i_item.node_id;
                        r_key   <= KEY_WIDTH'(i_item.key_in);
                        r_onode <= i_item.node_id;
                        r_pos   <= '0;
                        r_rd    <= 1'b0;
                        // insert and decrease key echo the new key
                        if (i_item.cmd == spq_pkg::CMD_INSERT
                            || i_item.cmd == spq_pkg::CMD_DECKEY) begin
                            r_okey <= KEY_WIDTH'(i_item.key_in);
                        end else begin
                            r_okey <= '0;
                        end
                        if (i_item.cmd == spq_pkg::CMD_INSERT) begin
                            r_st    <= spq_pkg::ST_DONE;
                            r_state <= S_PREP;
                        end else if (r_cnt == '0) begin
                            if (i_item.cmd == spq_pkg::CMD_DECKEY) begin
                                r_st    <= spq_pkg::ST_DONE;
                                r_state <= S_PREP;
                            end else begin
                                r_st    <= spq_pkg::ST_MISS;
                                r_state <= S_DONE;
                            end
                        end else begin
                            r_st    <= spq_pkg::ST_DONE;
                            r_state <= S_FIND;
                        end
                    end
                end
                S_FIND: begin
                    // issue reads in order, compare each in the cycle after its read
                    if (r_rd && (rd_id == r_id || r_cmd == spq_pkg::CMD_POP)) begin
                        if (r_cmd != spq_pkg::CMD_DECKEY) begin
                            r_onode <= rd_id;
                            r_okey  <= rd_key;
                        end else begin
                            r_okey  <= r_key;
                        end
                        // next read starts at the following entry
                        r_pos   <= r_rpos + CW'(1);
                        r_rd    <= 1'b0;
                        r_state <= S_DEL;
                    end else if (r_pos == r_cnt) begin
                        if (!r_rd || r_rpos + CW'(1) == r_cnt) begin
                            r_rd <= 1'b0;
                            if (r_cmd == spq_pkg::CMD_DECKEY) begin
                                r_okey  <= r_key;
                                r_state <= S_PREP;
                            end else begin
                                r_st    <= spq_pkg::ST_MISS;
                                r_state <= S_DONE;
                            end
                        end
                    end else begin
                        r_rpos <= r_pos;
                        r_pos  <= r_pos + CW'(1);
                        r_rd   <= 1'b1;
                    end
                end
                S_DEL: begin
                    if (r_pos < r_cnt) begin
                        r_rpos <= r_pos;
                        r_pos  <= r_pos + CW'(1);
                        r_rd   <= 1'b1;
                    end else if (!r_rd || r_rpos + CW'(1) == r_pos) begin
                        r_rd <= 1'b0;
                        if (!r_rd) begin
                            r_cnt <= r_cnt - CW'(1);
                            if (r_cmd == spq_pkg::CMD_DECKEY) begin
                                r_state <= S_PREP;
                            end else begin
                                r_state <= S_DONE;
                            end
                        end
                    end
                end
                S_PREP: begin
                    if (r_cnt == CW'(CAPACITY)) begin
                        r_st    <= spq_pkg::ST_FULL;
                        r_state <= S_DONE;
                    end else if (r_cnt == '0) begin
                        r_rd    <= 1'b0;
                        r_rpos  <= '1;
                        r_pos   <= '0;
                        r_state <= S_INS;
                    end else begin
                        // read top entry first
                        r_rpos  <= '0;
                        r_pos   <= r_cnt - CW'(1);
                        r_rd    <= 1'b0;
                        r_state <= S_INS;
                    end
                end
                S_INS: begin
                    if (r_rd) begin
                        if (rd_key > r_key && r_rpos != '0) begin
                            r_rpos <= r_rpos - CW'(1);
                            r_pos  <= r_rpos - CW'(2);
                            r_rd   <= 1'b1;
                        end else if (rd_key > r_key) begin
                            // shifted entry 0; new one goes to slot 0
                            r_rd   <= 1'b0;
                            r_rpos <= '1;
                            r_pos  <= '0;
                        end else begin
                            r_cnt   <= r_cnt + CW'(1);
                            r_rd    <= 1'b0;
                            r_state <= S_DONE;
                        end
                    end else if (r_pos == '0 && r_rpos == '1) begin
                        r_cnt   <= r_cnt + CW'(1);
                        r_state <= S_DONE;
                    end else begin
                        r_rpos <= r_pos;
                        r_pos  <= r_pos - CW'(1);
                        r_rd   <= 1'b1;
                    end
                end
                S_DONE: begin
                    r_state <= S_IDLE;
                end
                default: r_state <= S_IDLE;
            endcase
        end
    end

    always_comb begin
        o_item.out_node    = r_onode;
        o_item.out_key     = 32'(r_okey);
        o_item.status      = r_st;
        o_item.entry_count = 7'(r_cnt);
    end

    `SPQ_ASSERT_IMP(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CW'(CAPACITY), "count overflow")
    `SPQ_ASSERT_NEXT(a_done_idle, i_clk, i_rst_n, o_done, 1'b1, "done check")
    `SPQ_ASSERT_IMP(a_full_no_grow, i_clk, i_rst_n, o_done && r_st == spq_pkg::ST_FULL,
        r_cnt == CW'(CAPACITY), "full status with room")
endmodule

### rtl/spq_ram.sv
// Generic single-port-write, single-read RAM with registered read data.
// No dependencies.
module spq_ram #(
    parameter int WIDTH = 48,
    parameter int DEPTH = 64
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);
    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        o_rdata <= r_mem[i_raddr];
    end
endmodule
